FILE: hdl/srt_pkg.sv
// Shared types and constants for the sorted record table.
package srt_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int KEY_W = 64;
  localparam int VAL_W = 16;
  localparam int PAY_W = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [PAY_W-1:0] payload;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_CAPTURE = 3'd1,
    CELL_INSERT  = 3'd2,
    CELL_DELETE  = 3'd3,
    CELL_ROTATE  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    rec_t     rec;
  } cell_ctl_t;

endpackage

FILE: hdl/srt_if.sv
// Valid/ready channel interfaces for the request and result words.
interface srt_in_if;
  import srt_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] sort_value;
  logic [PAY_W-1:0] payload;

  modport source (output valid, opcode, key, sort_value, payload, input ready);
  modport sink   (input valid, opcode, key, sort_value, payload, output ready);
endinterface

interface srt_out_if;
  import srt_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] found_key;
  logic [VAL_W-1:0] found_value;
  logic [PAY_W-1:0] found_payload;
  logic             last;

  modport source (output valid, status, found_key, found_value, found_payload, last,
                  input ready);
  modport sink   (input valid, status, found_key, found_value, found_payload, last,
                  output ready);
endinterface

FILE: hdl/srt_cell.sv
// One table cell: holds a record, compares it and moves it to or from its neighbors.
module srt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srt_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]  count,
  input  logic              head_cond,
  input  logic              prev_at,
  input  logic              ge,
  input  srt_pkg::rec_t     prev_rec,
  input  srt_pkg::rec_t     next_rec,
  input  srt_pkg::rec_t     wrap_rec,
  output srt_pkg::rec_t     rec,
  output logic              at,
  output logic              match,
  output logic              cond
);
  import srt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  rec_t rec_r, rec_nxt;
  logic at_r, at_nxt;
  logic match_r, match_nxt;
  logic occ, is_count, is_tail;

  assign occ      = MY_IDX < count;
  assign is_count = MY_IDX == count;
  assign is_tail  = MY_IDX == (count - CNT_W'(1));

  // Head cell: a strictly larger value, or an empty table, takes the head.
  // Other cells: first occupied entry not larger, or the first free slot.
  assign cond = (IDX == 0) ? ((count == '0) || (ctl.rec.value > rec_r.value))
                           : ((occ && (rec_r.value <= ctl.rec.value)) || is_count);

  always_comb begin
    rec_nxt   = rec_r;
    at_nxt    = at_r;
    match_nxt = match_r;
    unique case (ctl.op)
      CELL_CAPTURE: begin
        at_nxt    = cond | head_cond;
        match_nxt = occ && (rec_r.key == ctl.rec.key);
      end
      CELL_INSERT: begin
        if (at_r) begin
          rec_nxt = prev_at ? prev_rec : ctl.rec;
        end
      end
      CELL_DELETE: begin
        if (ge) begin
          rec_nxt = next_rec;
        end
      end
      CELL_ROTATE: begin
        if (is_tail) begin
          rec_nxt = wrap_rec;
        end else if (occ) begin
          rec_nxt = next_rec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_r    <= 1'b0;
      match_r <= 1'b0;
    end else begin
      at_r    <= at_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec   = rec_r;
  assign at    = at_r;
  assign match = match_r;

endmodule

FILE: hdl/srt_chain.sv
// Row of table cells with neighbor wiring, delete shift mask and hit select.
module srt_chain #(
  parameter int CAPACITY = srt_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srt_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   count,
  output srt_pkg::rec_t      head_rec,
  output srt_pkg::rec_t      found_rec,
  output logic               hit
);
  import srt_pkg::*;

  rec_t                recs [CAPACITY];
  logic [CAPACITY-1:0] at_v, match_v, cond_v, ge_v, first_v, below_v;
  logic [REC_W-1:0]    found_bits;

  // Entries at or after the first hit shift down on delete.
  assign below_v = (match_v - CAPACITY'(1)) & ~match_v;
  assign ge_v    = ~below_v;
  assign first_v = match_v & (~match_v + CAPACITY'(1));
  assign hit     = |match_v;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_at;

    if (g == 0) begin : g_head
      assign prev_rec = recs[0];
      assign prev_at  = 1'b0;
    end else begin : g_body
      assign prev_rec = recs[g-1];
      assign prev_at  = at_v[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign next_rec = recs[g];
    end else begin : g_mid
      assign next_rec = recs[g+1];
    end

    srt_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count),
      .head_cond (cond_v[0]),
      .prev_at   (prev_at),
      .ge        (ge_v[g]),
      .prev_rec  (prev_rec),
      .next_rec  (next_rec),
      .wrap_rec  (recs[0]),
      .rec       (recs[g]),
      .at        (at_v[g]),
      .match     (match_v[g]),
      .cond      (cond_v[g])
    );
  end

  always_comb begin
    found_bits = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_v[i]) begin
        found_bits = found_bits | recs[i];
      end
    end
  end

  assign found_rec = rec_t'(found_bits);
  assign head_rec  = recs[0];

endmodule

FILE: hdl/sorted_record_table_unit.sv
// Top level of the sorted record table: control, entry count and result register.
//
// Sorted record table. Holds up to CAPACITY records (64-bit key, 16-bit sort
// value, 64-bit payload) in descending sort-value order in a row of cells. An
// insert goes ahead of the first lower-or-equal entry, but behind an equal head.
// Search and delete act on the first entry whose key matches; list returns every
// entry in order with last set on the final word. For insert, search and delete
// every cell compares itself against the request in parallel in the accept
// cycle; once the output register is free, the cells shift and the result word
// is loaded. For a list, after the decode cycle the row rotates by one cell per
// result word and the head cell is read out, so the table is back in order when
// the last word leaves. A list on an empty table gives one word
// with status empty. A missing key, a full table or an empty list report status
// codes with zero record fields. One request is in flight at a time; the input
// is ready again once its results are all in the output register, and the block
// stalls while a result word waits at the output. Contents are not cleared at
// reset; only occupied cells are ever read.
module sorted_record_table_unit #(
  parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst_n,
  srt_in_if.sink   in_ch,
  srt_out_if.source out_ch
);
  import srt_pkg::*;

  localparam int              CNT_W   = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_APPLY = 3'b010,
    ST_LIST  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  op_t              item_op_r;
  rec_t             item_rec_r;
  rec_t             in_rec;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic             out_last_r, out_last_nxt;
  logic             load_out, out_free, accept;

  cell_ctl_t        ctl;
  rec_t             head_rec, found_rec;
  logic             hit;

  assign in_rec = '{key: in_ch.key, value: in_ch.sort_value, payload: in_ch.payload};

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  // Result register is free when empty or being taken this cycle.
  assign out_free    = !out_valid_r || out_ch.ready;

  srt_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .count     (count_r),
    .head_rec  (head_rec),
    .found_rec (found_rec),
    .hit       (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    load_out       = 1'b0;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;
    ctl.op         = CELL_HOLD;
    // Compare against the live request; shift in the stored one.
    ctl.rec        = (state_r == ST_IDLE) ? in_rec : item_rec_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.op    = CELL_CAPTURE;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
          unique case (item_op_r)
            OP_INSERT: begin
              if (count_r == CAP_CNT) begin
                out_status_nxt = STAT_FULL;
                out_rec_nxt    = '0;
              end else begin
                out_status_nxt = STAT_OK;
                out_rec_nxt    = item_rec_r;
                ctl.op         = CELL_INSERT;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            OP_SEARCH, OP_DELETE: begin
              if (hit) begin
                out_status_nxt = STAT_OK;
                out_rec_nxt    = found_rec;
                if (item_op_r == OP_DELETE) begin
                  ctl.op    = CELL_DELETE;
                  count_nxt = count_r - CNT_W'(1);
                end
              end else begin
                out_status_nxt = STAT_MISSING;
                out_rec_nxt    = '0;
              end
            end
            OP_LIST: begin
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
                out_rec_nxt    = '0;
              end else begin
                load_out   = 1'b0;
                remain_nxt = count_r;
                state_nxt  = ST_LIST;
              end
            end
          endcase
        end
      end
      ST_LIST: begin
        // Head cell goes out, row rotates one place toward the head.
        if (out_free) begin
          load_out       = 1'b1;
          out_status_nxt = STAT_OK;
          out_rec_nxt    = head_rec;
          out_last_nxt   = (remain_r == CNT_W'(1));
          ctl.op         = CELL_ROTATE;
          remain_nxt     = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op_r  <= op_t'(in_ch.opcode);
      item_rec_r <= in_rec;
    end
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.found_key     = out_rec_r.key;
  assign out_ch.found_value   = out_rec_r.value;
  assign out_ch.found_payload = out_rec_r.payload;
  assign out_ch.last          = out_last_r;

  // Entry count never passes capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  // A list walk always has words left and never more than the table holds.
  a_list_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> ((remain_r != '0) && (remain_r <= count_r)))
    else $error("list walk count out of range");

  // An insert shift grows the table by exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == CELL_INSERT) |=> (count_r == ($past(count_r) + CNT_W'(1))))
    else $error("insert did not grow table by one");

  // A delete shift is only issued on a key hit.
  a_delete_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == CELL_DELETE) |-> hit)
    else $error("delete shift without key hit");

endmodule
